FILE: hdl/rsfe_pkg.sv
// ----------------------------------------------------------------------------
// rsfe_pkg
// shared types and constants of the regular-solution free energy block
// ----------------------------------------------------------------------------
package rsfe_pkg;

    localparam int C_W       = 16;   // concentration, unsigned Q0.16
    localparam int OUT_W     = 40;   // signed Q23.f results
    localparam int KAPPA_W   = 24;
    localparam int COEFF_W   = 24;
    localparam int CHI_W     = 25;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOBILITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHI      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KAPPA    = 2'd2;

    // log2 by repeated squaring, one fraction bit per stage
    localparam int LOG_STEPS = 32;
    // reciprocal 2^56/x by restoring division, two quotient bits per stage
    localparam int DIV_W     = 2 * LOG_STEPS;
    localparam int DIV_POINT = 56;
    localparam int Q_W       = 57;
    // -ln magnitude, Q40
    localparam int L_W       = 46;

    localparam logic [30:0] LN2_Q31 = 31'd1488522236;

    typedef struct packed {
        logic [31:0]    m;
        logic [31:0]    frac;
        logic [3:0]     k;
        logic [C_W-1:0] rem;
        logic [Q_W-1:0] q;
    } t_lane;

    typedef struct packed {
        logic [C_W-1:0] a;
        logic [C_W-1:0] b;
        logic [31:0]    ab;
        logic [C_W:0]   diff;   // b - a, two's complement
        logic           oor;
    } t_side;

    typedef struct packed {
        logic [OUT_W-1:0]   mobility;
        logic [OUT_W-1:0]   mobility_slope;
        logic [OUT_W-1:0]   free_energy;
        logic [OUT_W-1:0]   chem_potential;
        logic [OUT_W-1:0]   curvature;
        logic [KAPPA_W-1:0] kappa_out;
        logic               out_of_range;
    } t_result;

endpackage

FILE: hdl/regular_solution_free_energy_top.sv
// ----------------------------------------------------------------------------
// regular_solution_free_energy_top
// throughput: one item per cycle while the skid entry is free; set by the 32-stage log2 squaring chain,
//   one 32x32 multiply per stage, running beside a 2-bit-per-stage divider
// a 2-entry output register/skid pair keeps the pipeline moving while a
//   result waits; the pipeline stalls as a whole only once the skid is full
// reset: synchronous active low, clears all valid bits and loads registers
//   with D = 1.0, chi = 0, kappa = 0
// ----------------------------------------------------------------------------
module regular_solution_free_energy_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [rsfe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rsfe_pkg::CFG_W-1:0]         i_cfg_data,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [rsfe_pkg::C_W-1:0]           i_concentration,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [rsfe_pkg::OUT_W-1:0]  o_mobility,
    output logic signed [rsfe_pkg::OUT_W-1:0]  o_mobility_slope,
    output logic signed [rsfe_pkg::OUT_W-1:0]  o_free_energy,
    output logic signed [rsfe_pkg::OUT_W-1:0]  o_chem_potential,
    output logic signed [rsfe_pkg::OUT_W-1:0]  o_curvature,
    output logic [rsfe_pkg::KAPPA_W-1:0]       o_kappa_out,
    output logic                               o_out_of_range
);
    import rsfe_pkg::*;

    // fixed-point alignment shifts that follow the fraction width
    localparam int SH_CHI_AB = FRAC_BITS - 8;
    localparam int SH_DF     = 24 - FRAC_BITS;
    localparam int SH_D2     = 41 - FRAC_BITS;   // 2 * chi * 2^(40-f)
    localparam int SH_OUT    = 40 - FRAC_BITS;
    localparam logic [COEFF_W-1:0] COEFF_ONE = COEFF_W'(1 << FRAC_BITS);

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // normalize x to Q1.31 and note its top set bit
    function automatic t_lane lane_init(input logic [C_W-1:0] x);
        t_lane l;
        l = '0;
        for (int i = 0; i < C_W; i++) begin
            if (x[i]) l.k = 4'(i);
        end
        l.m = 32'(x) << (5'd31 - {1'b0, l.k});
        return l;
    endfunction

    // one squaring step of log2 and two restoring division steps
    function automatic t_lane lane_step(input t_lane li, input logic bit_hi,
                                        input logic bit_lo, input logic [C_W-1:0] d);
        t_lane       l;
        logic [63:0] sq;
        logic [32:0] t;
        logic [C_W:0] r;
        logic        qb_hi;
        logic        qb_lo;
        l  = li;
        sq = 64'(li.m) * 64'(li.m);
        t  = sq[63:31];
        if (t[32]) begin
            l.m    = t[32:1];
            l.frac = {li.frac[30:0], 1'b1};
        end else begin
            l.m    = t[31:0];
            l.frac = {li.frac[30:0], 1'b0};
        end
        r = {li.rem, bit_hi};
        if (r >= {1'b0, d}) begin
            r     = r - {1'b0, d};
            qb_hi = 1'b1;
        end else begin
            qb_hi = 1'b0;
        end
        r = {r[C_W-1:0], bit_lo};
        if (r >= {1'b0, d}) begin
            r     = r - {1'b0, d};
            qb_lo = 1'b1;
        end else begin
            qb_lo = 1'b0;
        end
        l.rem = r[C_W-1:0];
        l.q   = {li.q[Q_W-3:0], qb_hi, qb_lo};
        return l;
    endfunction

    // clamp to the signed 40 bit range
    function automatic logic [OUT_W-1:0] sat40(input logic signed [63:0] v);
        if ((&v[63:OUT_W-1]) || !(|v[63:OUT_W-1])) begin
            return v[OUT_W-1:0];
        end else if (v[63]) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [COEFF_W-1:0]      r_coeff;
    logic signed [CHI_W-1:0] r_chi;
    logic [KAPPA_W-1:0]      r_kappa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= COEFF_ONE;
            r_chi   <= '0;
            r_kappa <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MOBILITY: r_coeff <= i_cfg_data[COEFF_W-1:0];
                CFG_CHI:      r_chi   <= $signed(i_cfg_data[CHI_W-1:0]);
                CFG_KAPPA:    r_kappa <= i_cfg_data[KAPPA_W-1:0];
                default: ;    // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline advance: whole pipe moves unless the skid entry is busy
    // ------------------------------------------------------------------
    logic r_skid_v;
    logic en;

    assign en         = !r_skid_v;
    assign o_in_ready = en;

    // stage 1: input capture
    logic           r_v1;
    logic [C_W-1:0] r_a1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1 <= i_concentration;
        end
    end

    // stage 2: split c and 1-c, normalize both for log2
    t_side n_side0;

    always_comb begin
        n_side0.a    = r_a1;
        n_side0.b    = C_W'(17'h10000 - {1'b0, r_a1});   // wraps to 0 only when c = 0
        n_side0.ab   = 32'(n_side0.a) * 32'(n_side0.b);
        n_side0.diff = {1'b0, n_side0.b} - {1'b0, r_a1};
        n_side0.oor  = (r_a1 == '0);
    end

    t_lane r_lane_a [0:LOG_STEPS];
    t_lane r_lane_b [0:LOG_STEPS];
    t_side r_side   [0:LOG_STEPS];
    logic  r_vc     [0:LOG_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc[0] <= 1'b0;
        end else if (en) begin
            r_vc[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0]   <= n_side0;
            r_lane_a[0] <= lane_init(n_side0.a);
            r_lane_b[0] <= lane_init(n_side0.b);
        end
    end

    // log2 fraction bits and reciprocal quotient bits, one stage per step;
    // the dividend 2^56 is a single one bit fed in at its position
    for (genvar j = 1; j <= LOG_STEPS; j++) begin : g_iter
        localparam int BH = DIV_W + 1 - 2 * j;
        localparam int BL = DIV_W - 2 * j;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vc[j] <= 1'b0;
            end else if (en) begin
                r_vc[j] <= r_vc[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_lane_a[j] <= lane_step(r_lane_a[j-1], 1'(BH == DIV_POINT),
                                         1'(BL == DIV_POINT), r_side[j-1].a);
                r_lane_b[j] <= lane_step(r_lane_b[j-1], 1'(BH == DIV_POINT),
                                         1'(BL == DIV_POINT), r_side[j-1].b);
                r_side[j]   <= r_side[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // P1: log2 to -ln, partial products against ln 2
    // ------------------------------------------------------------------
    logic [4:0]  n_km_a, n_km_b;
    logic [36:0] n_g_a, n_g_b;

    always_comb begin
        n_km_a = 5'd16 - {1'b0, r_lane_a[LOG_STEPS].k};
        n_km_b = 5'd16 - {1'b0, r_lane_b[LOG_STEPS].k};
        n_g_a  = {n_km_a, 32'b0} - {5'b0, r_lane_a[LOG_STEPS].frac};
        n_g_b  = {n_km_b, 32'b0} - {5'b0, r_lane_b[LOG_STEPS].frac};
    end

    logic           r_vp1;
    t_side          r_side_p1;
    logic [Q_W-1:0] r_qa_p1, r_qb_p1;
    logic [51:0]    r_hp_a, r_hp_b;
    logic [46:0]    r_lp_a, r_lp_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp1 <= 1'b0;
        end else if (en) begin
            r_vp1 <= r_vc[LOG_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side_p1 <= r_side[LOG_STEPS];
            r_qa_p1   <= r_lane_a[LOG_STEPS].q;
            r_qb_p1   <= r_lane_b[LOG_STEPS].q;
            r_hp_a    <= 52'(n_g_a[36:16]) * 52'(LN2_Q31);
            r_hp_b    <= 52'(n_g_b[36:16]) * 52'(LN2_Q31);
            r_lp_a    <= 47'(n_g_a[15:0]) * 47'(LN2_Q31);
            r_lp_b    <= 47'(n_g_b[15:0]) * 47'(LN2_Q31);
        end
    end

    // ------------------------------------------------------------------
    // P2: finish -ln in Q40, products with chi and D
    // ------------------------------------------------------------------
    logic [52:0] n_ls_a, n_ls_b;

    always_comb begin
        n_ls_a = 53'(r_hp_a) + 53'(r_lp_a[46:16]);
        n_ls_b = 53'(r_hp_b) + 53'(r_lp_b[46:16]);
    end

    logic               r_vp2;
    t_side              r_side_p2;
    logic [Q_W-1:0]     r_qa_p2, r_qb_p2;
    logic [L_W-1:0]     r_la, r_lb;
    logic signed [57:0] r_chi_ab;
    logic signed [41:0] r_chi_diff;
    logic [55:0]        r_d_ab;
    logic signed [41:0] r_d_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp2 <= 1'b0;
        end else if (en) begin
            r_vp2 <= r_vp1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side_p2  <= r_side_p1;
            r_qa_p2    <= r_qa_p1;
            r_qb_p2    <= r_qb_p1;
            r_la       <= n_ls_a[52:7];
            r_lb       <= n_ls_b[52:7];
            r_chi_ab   <= r_chi * $signed({1'b0, r_side_p1.ab});
            r_chi_diff <= r_chi * $signed(r_side_p1.diff);
            r_d_ab     <= 56'(r_coeff) * 56'(r_side_p1.ab);
            r_d_diff   <= $signed({1'b0, r_coeff}) * $signed(r_side_p1.diff);
        end
    end

    // ------------------------------------------------------------------
    // P3: entropy products, first and second derivative sums
    // ------------------------------------------------------------------
    logic                r_vp3;
    logic                r_oor_p3;
    logic [61:0]         r_fa, r_fb;
    logic signed [57:0]  r_chi_ab_sh;
    logic signed [63:0]  r_df, r_d2f, r_slope;
    logic [23:0]         r_mob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp3 <= 1'b0;
        end else if (en) begin
            r_vp3 <= r_vp2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oor_p3    <= r_side_p2.oor;
            r_fa        <= 62'(r_side_p2.a) * 62'(r_la);
            r_fb        <= 62'(r_side_p2.b) * 62'(r_lb);
            r_chi_ab_sh <= r_chi_ab >>> SH_CHI_AB;
            r_df        <= $signed(64'(r_lb)) - $signed(64'(r_la))
                           + (64'(r_chi_diff) <<< SH_DF);
            r_d2f       <= $signed(64'(r_qa_p2)) + $signed(64'(r_qb_p2))
                           - (64'(r_chi) <<< SH_D2);
            r_slope     <= 64'(r_d_diff >>> 16);
            r_mob       <= r_d_ab[55:32];
        end
    end

    // ------------------------------------------------------------------
    // P4: free energy sum, output scaling, saturation, zero on c = 0
    // ------------------------------------------------------------------
    logic signed [63:0] n_f;
    t_result            n_res;

    always_comb begin
        n_f = 64'(r_chi_ab_sh) - $signed(64'(r_fa[61:16])) - $signed(64'(r_fb[61:16]));
        n_res = '0;
        if (r_oor_p3) begin
            n_res.out_of_range = 1'b1;
        end else begin
            n_res.mobility       = OUT_W'(r_mob);
            n_res.mobility_slope = sat40(r_slope);
            n_res.free_energy    = sat40(n_f >>> SH_OUT);
            n_res.chem_potential = sat40(r_df >>> SH_OUT);
            n_res.curvature      = sat40(r_d2f >>> SH_OUT);
            n_res.kappa_out      = r_kappa;
        end
    end

    logic    r_vp4;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp4 <= 1'b0;
        end else if (en) begin
            r_vp4 <= r_vp3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

    // ------------------------------------------------------------------
    // output register with skid entry
    // ------------------------------------------------------------------
    logic    r_out_v;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r_vp4;
            end
        end else if (en && r_vp4) begin
            // result blocked, park the tail item
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : r_res;
        end
        if (!out_free && en && r_vp4) begin
            r_skid <= r_res;
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_mobility       = $signed(r_out.mobility);
    assign o_mobility_slope = $signed(r_out.mobility_slope);
    assign o_free_energy    = $signed(r_out.free_energy);
    assign o_chem_potential = $signed(r_out.chem_potential);
    assign o_curvature      = $signed(r_out.curvature);
    assign o_kappa_out      = r_out.kappa_out;
    assign o_out_of_range   = r_out.out_of_range;

endmodule

FILE: hdl/rsfe_check.sv
// ----------------------------------------------------------------------------
// rsfe_check
// port-level checks of the regular-solution free energy block
// ----------------------------------------------------------------------------
module rsfe_check (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [rsfe_pkg::OUT_W-1:0]  o_mobility,
    input logic signed [rsfe_pkg::OUT_W-1:0]  o_mobility_slope,
    input logic signed [rsfe_pkg::OUT_W-1:0]  o_free_energy,
    input logic signed [rsfe_pkg::OUT_W-1:0]  o_chem_potential,
    input logic signed [rsfe_pkg::OUT_W-1:0]  o_curvature,
    input logic [rsfe_pkg::KAPPA_W-1:0]       o_kappa_out,
    input logic                               o_out_of_range
);
    import rsfe_pkg::*;

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // an out-of-range item, from zero concentration, has all value fields zero
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |->
            (o_mobility == '0 && o_mobility_slope == '0 && o_free_energy == '0 &&
             o_chem_potential == '0 && o_curvature == '0 && o_kappa_out == '0))
        else $error("out-of-range item with nonzero fields");

    // mobility is never negative
    a_mob_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_mobility[OUT_W-1])
        else $error("negative mobility");

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_free_energy) && $stable(o_curvature) &&
             $stable(o_out_of_range)))
        else $error("stalled result changed");

endmodule

bind regular_solution_free_energy_top rsfe_check u_rsfe_check (.*);

FILE: sim/rsfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfe_checker
// watches the configuration port and both channels of the free energy block,
// computes the expected result of every accepted item and compares in order
// ----------------------------------------------------------------------------
module rsfe_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rsfe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rsfe_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [rsfe_pkg::C_W-1:0]           i_concentration,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [rsfe_pkg::OUT_W-1:0]         i_mobility,
    input  logic [rsfe_pkg::OUT_W-1:0]         i_mobility_slope,
    input  logic [rsfe_pkg::OUT_W-1:0]         i_free_energy,
    input  logic [rsfe_pkg::OUT_W-1:0]         i_chem_potential,
    input  logic [rsfe_pkg::OUT_W-1:0]         i_curvature,
    input  logic [rsfe_pkg::KAPPA_W-1:0]       i_kappa_out,
    input  logic                               i_out_of_range,
    output int                                 o_fail_count
);
    import rsfe_pkg::*;

    localparam int     FB      = 16;
    localparam longint LN2     = 64'd1488522236;
    localparam longint SAT_HI  = 64'sd549755813887;
    localparam longint SAT_LO  = -64'sd549755813888;

    longint    coeff_d;
    longint    chi;
    longint    kappa;
    t_result   pending_q[$];
    int        mismatches;

    // -ln(x / 65536) in Q40 for x in 1..65535
    function automatic longint minus_ln(input longint x);
        bit [63:0] m;
        bit [63:0] frac;
        bit [63:0] g;
        bit [63:0] hi;
        bit [63:0] lo;
        int        k;
        k    = 0;
        frac = 0;
        for (int i = 0; i < 16; i++)
            if (x[i]) k = i;
        m = 64'(x) << (31 - k);
        for (int i = 0; i < 32; i++) begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 64'd1;
                m    = m >> 1;
            end
        end
        g  = (64'd16 << 32) - ((64'(k) << 32) + frac);
        hi = g >> 16;
        lo = g & 64'hFFFF;
        return longint'((hi * LN2 + ((lo * LN2) >> 16)) >> 7);
    endfunction

    function automatic logic [OUT_W-1:0] clip40(input longint v);
        if (v > SAT_HI) v = SAT_HI;
        if (v < SAT_LO) v = SAT_LO;
        return v[OUT_W-1:0];
    endfunction

    function automatic t_result free_energy_of(input logic [C_W-1:0] c);
        t_result r;
        longint  a, b, ab, diff, la, lb, f, df, d2f;
        r = '0;
        if (c == '0) begin
            r.out_of_range = 1'b1;
            return r;
        end
        a    = longint'(c);
        b    = 65536 - a;
        ab   = a * b;
        diff = b - a;
        la   = minus_ln(a);
        lb   = minus_ln(b);
        f    = -((a * la) >> 16) - ((b * lb) >> 16) + ((chi * ab) >>> (FB - 8));
        df   = lb - la + chi * diff * (64'sd1 <<< (24 - FB));
        d2f  = ((64'sd1 <<< 56) / a) + ((64'sd1 <<< 56) / b)
             - 2 * chi * (64'sd1 <<< (40 - FB));
        r.mobility       = clip40((coeff_d * ab) >>> 32);
        r.mobility_slope = clip40((coeff_d * diff) >>> 16);
        r.free_energy    = clip40(f >>> (40 - FB));
        r.chem_potential = clip40(df >>> (40 - FB));
        r.curvature      = clip40(d2f >>> (40 - FB));
        r.kappa_out      = kappa[KAPPA_W-1:0];
        return r;
    endfunction

    function automatic int field_ok(input string name, input logic [OUT_W-1:0] exp_v,
                                    input logic [OUT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        logic signed [CHI_W-1:0] chi_raw;
        int errs;
        if (!i_rst_n) begin
            coeff_d    <= 65536;
            chi        <= 0;
            kappa      <= 0;
            mismatches <= 0;
            pending_q.delete();
            o_fail_count <= 0;
        end else begin
            errs = 0;
            if (i_cfg_we) begin
                chi_raw = i_cfg_data[CHI_W-1:0];
                case (i_cfg_idx)
                    CFG_MOBILITY: coeff_d <= longint'(i_cfg_data[COEFF_W-1:0]);
                    CFG_CHI:      chi     <= longint'(chi_raw);
                    CFG_KAPPA:    kappa   <= longint'(i_cfg_data[KAPPA_W-1:0]);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got mobility %h",
                             $realtime, i_mobility);
                    errs++;
                end else begin
                    exp_r = pending_q.pop_front();
                    errs += field_ok("mobility", exp_r.mobility, i_mobility);
                    errs += field_ok("mobility_slope", exp_r.mobility_slope, i_mobility_slope);
                    errs += field_ok("free_energy", exp_r.free_energy, i_free_energy);
                    errs += field_ok("chem_potential", exp_r.chem_potential, i_chem_potential);
                    errs += field_ok("curvature", exp_r.curvature, i_curvature);
                    errs += field_ok("kappa_out", 40'(exp_r.kappa_out), 40'(i_kappa_out));
                    errs += field_ok("out_of_range", 40'(exp_r.out_of_range),
                                     40'(i_out_of_range));
                end
            end
            if (i_in_valid && i_in_ready)
                pending_q.push_back(free_energy_of(i_concentration));
            mismatches   <= mismatches + errs;
            o_fail_count <= mismatches + errs + pending_q.size();
        end
    end

endmodule

FILE: sim/regular_solution_free_energy_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regular_solution_free_energy_top_tb
// streams concentration items through the free energy block under several
// register settings and handshake pressure; a checker beside the block
// predicts and compares every result
// ----------------------------------------------------------------------------
module regular_solution_free_energy_top_tb;
    import rsfe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;   // no register here
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_WAIT     = 50;                   // settling wait after a drain, in cycles
    localparam int BATCH          = 285;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [C_W-1:0]     i_concentration;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [OUT_W-1:0] o_mobility, o_mobility_slope, o_free_energy;
    logic signed [OUT_W-1:0] o_chem_potential, o_curvature;
    logic [KAPPA_W-1:0] o_kappa_out;
    logic               o_out_of_range;

    int fail_count;
    int items_in, items_out;
    int quiet_cycles;
    int send_idle_pct, recv_idle_pct;
    int hold_off;            // receiver stall request, in cycles

    regular_solution_free_energy_top DUT (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .o_in_ready, .i_concentration,
        .o_out_valid, .i_out_ready,
        .o_mobility, .o_mobility_slope, .o_free_energy, .o_chem_potential,
        .o_curvature, .o_kappa_out, .o_out_of_range
    );

    rsfe_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_concentration,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_mobility(o_mobility), .i_mobility_slope(o_mobility_slope),
        .i_free_energy(o_free_energy), .i_chem_potential(o_chem_potential),
        .i_curvature(o_curvature), .i_kappa_out(o_kappa_out),
        .i_out_of_range(o_out_of_range), .o_fail_count(fail_count)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // handshake counters and the watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            items_in     <= 0;
            items_out    <= 0;
            quiet_cycles <= 0;
        end else begin
            if (i_in_valid && o_in_ready) items_in <= items_in + 1;
            if (o_out_valid && i_out_ready) items_out <= items_out + 1;
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_out_ready = 1'b0;
                hold_off    = hold_off - 1;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // one register write at the falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // offer one item, holding valid until it is taken; valid drops only on a gap
    task automatic offer_sample(input logic [C_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_concentration = c;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
    endtask

    // mostly uniform, with weight on the ends where the logs get steep
    function automatic logic [C_W-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 3)  return '0;
        if (r < 18) return C_W'($urandom_range(300));
        if (r < 33) return C_W'($urandom_range(65535, 65235));
        return C_W'($urandom);
    endfunction

    // drain, then let the pipeline settle before a new setting is loaded
    task automatic drain();
        i_in_valid = 1'b0;
        while (items_out != items_in) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic random_batch(input int n);
        for (int i = 0; i < n; i++) offer_sample(pick_sample());
    endtask

    initial begin
        logic [C_W-1:0] directed[$];
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_MOBILITY;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_concentration = '0;
        send_idle_pct   = 30;
        recv_idle_pct   = 85;
        hold_off        = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: zero, both ends, the midpoint, powers of two and other bit patterns, at reset values
        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'hFFFE, 16'hFFFD,
                     16'h8000, 16'h7FFF, 16'h8001, 16'h0100, 16'h1000, 16'h4000,
                     16'hC000, 16'h5555, 16'hAAAA, 16'h0000, 16'h00FF};
        foreach (directed[i]) offer_sample(directed[i]);
        drain();

        // all registers at their top, bit above the width set on the unsigned ones
        write_reg(CFG_MOBILITY, 25'h1FF_FFFF);
        write_reg(CFG_CHI, 25'h0FF_FFFF);
        write_reg(CFG_KAPPA, 25'h1FF_FFFF);
        write_reg(CFG_UNUSED, 25'h0AB_CDEF);      // must be ignored
        foreach (directed[i]) offer_sample(directed[i]);
        // long receiver stall while items keep coming, so the input backs up
        hold_off = 400;
        random_batch(BATCH);
        drain();

        // bottom of every range
        write_reg(CFG_MOBILITY, '0);
        write_reg(CFG_CHI, 25'h100_0000);
        write_reg(CFG_KAPPA, '0);
        random_batch(BATCH);
        drain();

        // sender idles more than the receiver from here
        send_idle_pct = 85;
        recv_idle_pct = 30;
        for (int p = 0; p < 2; p++) begin
            write_reg(CFG_MOBILITY, CFG_W'($urandom));
            write_reg(CFG_CHI, CFG_W'($urandom));
            write_reg(CFG_KAPPA, CFG_W'($urandom));
            random_batch(BATCH);
            drain();
        end

        // no idling at all, a mild and a random setting
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_MOBILITY, 25'd65536);
        write_reg(CFG_CHI, 25'h1FE_0000);         // chi = -2
        write_reg(CFG_KAPPA, 25'd12345);
        random_batch(BATCH);
        drain();
        write_reg(CFG_MOBILITY, CFG_W'($urandom));
        write_reg(CFG_CHI, CFG_W'($urandom));
        write_reg(CFG_KAPPA, CFG_W'($urandom));
        random_batch(BATCH);
        drain();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/rsfe_pkg.sv
hdl/regular_solution_free_energy_top.sv
hdl/rsfe_check.sv
sim/rsfe_checker.sv
sim/regular_solution_free_energy_top_tb.sv
